### src/pdc_pkg.sv
package pdc_pkg;

    localparam int ANGLE_W = 16;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DERIV_W = 32;
    localparam int IDX_W   = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_HIGH = 3'd4;
    localparam logic [IDX_W-1:0] REG_DRIVE_LOW  = 3'd5;

    localparam logic [15:0] RST_TARGET     = 16'h0000;
    localparam logic [15:0] RST_GAIN_P     = 16'h0100;
    localparam logic [15:0] RST_GAIN_I     = 16'h0000;
    localparam logic [15:0] RST_GAIN_D     = 16'h0000;
    localparam logic [15:0] RST_DRIVE_HIGH = 16'h7FFF;
    localparam logic [15:0] RST_DRIVE_LOW  = 16'h8000;

    localparam logic [3:0] LAST_GAIN_BIT = 4'd15;
    localparam logic [4:0] LAST_QUOT_BIT = 5'd31;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_SAT,
        ST_MAC,
        ST_DONE
    } state_t;

    typedef enum logic [1:0]
    {
        TERM_P,
        TERM_I,
        TERM_D
    } term_t;

endpackage

### src/pid_drive_with_clamp.sv
// PID drive with output clamp. Each input word carries an angle and an interval (tdata) and a
// restart flag (tuser); each accepted word yields exactly one output word. A restart skips the
// arithmetic and goes straight to the final stage that loads the output register. A control
// step latches the word, runs the bit-serial restoring divider that forms the derivative (the
// integral's 16-step shift-add multiply runs alongside it), saturates the integral and
// derivative, runs the shared shift-add multiplier that walks the 16 bits of each of the three
// gains in turn, and clamps. The input is accepted only while the core is idle; the output
// register holds a finished word until it is taken, and the core waits at the end of a step
// only if the previous word is still unclaimed. Configuration writes are always accepted and
// must only be issued while no step is in progress; register indexes past the list are dropped.
module pid_drive_with_clamp #(
    parameter int SUM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // angle[15:0], interval[31:16]
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // drive[15:0], remaining[32:16], zero[39:33]
    output logic        m_axis_tuser,   // clamped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int TERM_W = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;
    localparam int ACC_W  = TERM_W + 17;
    localparam int VAL_W  = ACC_W - 12;
    localparam int PROD_W = 33;

    pdc_pkg::state_t state_reg, state_next;
    pdc_pkg::term_t  term_reg;

    logic [15:0] target_reg, gain_p_reg, gain_i_reg, gain_d_reg, drive_high_reg, drive_low_reg;
    logic [15:0] last_reg;
    logic [SUM_WIDTH-1:0] esum_reg;

    logic        cmd_reg;
    logic [16:0] err_reg;
    logic [15:0] dt_reg;
    logic        neg_reg;
    logic [31:0] quot_reg;
    logic [15:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] imul_reg;
    logic [PROD_W-1:0] icand_reg, iacc_reg;
    logic [31:0] deriv_reg;
    logic [ACC_W-1:0] mcand_reg, acc_reg;
    logic [15:0] mplier_reg;

    logic        m_valid_reg;
    logic [15:0] drive_reg;
    logic [16:0] remain_reg;
    logic        clamp_reg;

    logic        accept;
    logic        load_out;
    logic [15:0] in_angle, in_dt;
    logic [16:0] in_err, in_diff, in_mag;
    logic [16:0] rem_sh, rem_sub;
    logic        quot_bit;
    logic [ACC_W-1:0] addend;
    logic [16:0] isum_inc;
    logic [SUM_WIDTH:0] esum_wide;
    logic [SUM_WIDTH-1:0] esum_new;
    logic [31:0] deriv_new;
    logic signed [VAL_W-1:0] value, vhi_ext, vlo_ext;
    logic [15:0] drive_new;
    logic        clamp_new;

    assign cfg_ready = 1'b1;

    assign in_angle = s_axis_tdata[15:0];
    assign in_dt    = s_axis_tdata[31:16];
    assign in_err   = {target_reg[15], target_reg} - {in_angle[15], in_angle};
    assign in_diff  = {last_reg[15], last_reg} - {in_angle[15], in_angle};
    assign in_mag   = in_diff[16] ? (17'd0 - in_diff) : in_diff;

    assign rem_sh   = {rem_reg, quot_reg[31]};
    assign rem_sub  = rem_sh - {1'b0, dt_reg};
    assign quot_bit = (rem_sh >= {1'b0, dt_reg});

    assign addend = mplier_reg[0] ? mcand_reg : '0;

    assign isum_inc  = iacc_reg[32:16];
    assign esum_wide = {esum_reg[SUM_WIDTH-1], esum_reg}
                     + {{(SUM_WIDTH-16){isum_inc[16]}}, isum_inc};

    always_comb
    begin
        if (esum_wide[SUM_WIDTH] != esum_wide[SUM_WIDTH-1])
        begin
            esum_new = esum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                            : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            esum_new = esum_wide[SUM_WIDTH-1:0];
        end
    end

    always_comb
    begin
        if (dt_reg == 16'd0)
        begin
            deriv_new = 32'd0;
        end
        else if (!neg_reg)
        begin
            deriv_new = quot_reg[31] ? 32'h7FFF_FFFF : quot_reg;
        end
        else if (quot_reg[31] && (|quot_reg[30:0]))
        begin
            deriv_new = 32'h8000_0000;
        end
        else
        begin
            deriv_new = 32'd0 - quot_reg;
        end
    end

    assign value   = $signed(acc_reg[ACC_W-1:12]);
    assign vhi_ext = $signed({{(VAL_W-16){drive_high_reg[15]}}, drive_high_reg});
    assign vlo_ext = $signed({{(VAL_W-16){drive_low_reg[15]}}, drive_low_reg});

    always_comb
    begin
        drive_new = value[15:0];
        clamp_new = 1'b0;
        if (cmd_reg)
        begin
            drive_new = 16'd0;
        end
        else if (value > vhi_ext)
        begin
            drive_new = drive_high_reg;
            clamp_new = 1'b1;
        end
        else if (value < vlo_ext)
        begin
            drive_new = drive_low_reg;
            clamp_new = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            pdc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = s_axis_tuser ? pdc_pkg::ST_DONE : pdc_pkg::ST_DIV;
                end
            end
            pdc_pkg::ST_DIV:
            begin
                if (cnt_reg == pdc_pkg::LAST_QUOT_BIT)
                begin
                    state_next = pdc_pkg::ST_SAT;
                end
            end
            pdc_pkg::ST_SAT:
            begin
                state_next = pdc_pkg::ST_MAC;
            end
            pdc_pkg::ST_MAC:
            begin
                if (cnt_reg[3:0] == pdc_pkg::LAST_GAIN_BIT && term_reg == pdc_pkg::TERM_D)
                begin
                    state_next = pdc_pkg::ST_DONE;
                end
            end
            pdc_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = pdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdc_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pdc_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            target_reg     <= pdc_pkg::RST_TARGET;
            gain_p_reg     <= pdc_pkg::RST_GAIN_P;
            gain_i_reg     <= pdc_pkg::RST_GAIN_I;
            gain_d_reg     <= pdc_pkg::RST_GAIN_D;
            drive_high_reg <= pdc_pkg::RST_DRIVE_HIGH;
            drive_low_reg  <= pdc_pkg::RST_DRIVE_LOW;
            last_reg       <= '0;
            esum_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pdc_pkg::REG_TARGET:     target_reg     <= cfg_data;
                    pdc_pkg::REG_GAIN_P:     gain_p_reg     <= cfg_data;
                    pdc_pkg::REG_GAIN_I:     gain_i_reg     <= cfg_data;
                    pdc_pkg::REG_GAIN_D:     gain_d_reg     <= cfg_data;
                    pdc_pkg::REG_DRIVE_HIGH: drive_high_reg <= cfg_data;
                    pdc_pkg::REG_DRIVE_LOW:  drive_low_reg  <= cfg_data;
                    default:                 ;
                endcase
            end

            if (accept)
            begin
                last_reg <= in_angle;
                if (s_axis_tuser)
                begin
                    esum_reg <= '0;
                end
            end
            else if (state_reg == pdc_pkg::ST_SAT)
            begin
                esum_reg <= esum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pdc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg   <= s_axis_tuser;
                    err_reg   <= in_err;
                    dt_reg    <= in_dt;
                    neg_reg   <= in_diff[16];
                    quot_reg  <= {in_mag[15:0], 16'd0};
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    imul_reg  <= in_dt;
                    icand_reg <= {{(PROD_W-17){in_err[16]}}, in_err};
                    iacc_reg  <= '0;
                end
            end
            pdc_pkg::ST_DIV:
            begin
                rem_reg   <= quot_bit ? rem_sub[15:0] : rem_sh[15:0];
                quot_reg  <= {quot_reg[30:0], quot_bit};
                cnt_reg   <= cnt_reg + 5'd1;
                iacc_reg  <= iacc_reg + (imul_reg[0] ? icand_reg : '0);
                icand_reg <= {icand_reg[PROD_W-2:0], 1'b0};
                imul_reg  <= {1'b0, imul_reg[15:1]};
            end
            pdc_pkg::ST_SAT:
            begin
                deriv_reg  <= deriv_new;
                mcand_reg  <= {{(ACC_W-17){err_reg[16]}}, err_reg};
                mplier_reg <= gain_p_reg;
                term_reg   <= pdc_pkg::TERM_P;
                acc_reg    <= '0;
                cnt_reg    <= '0;
            end
            pdc_pkg::ST_MAC:
            begin
                // top gain bit carries negative weight
                if (cnt_reg[3:0] == pdc_pkg::LAST_GAIN_BIT)
                begin
                    acc_reg <= acc_reg - addend;
                    cnt_reg <= '0;
                    case (term_reg)
                        pdc_pkg::TERM_P:
                        begin
                            term_reg   <= pdc_pkg::TERM_I;
                            mcand_reg  <= {{(ACC_W-SUM_WIDTH){esum_reg[SUM_WIDTH-1]}}, esum_reg};
                            mplier_reg <= gain_i_reg;
                        end
                        pdc_pkg::TERM_I:
                        begin
                            term_reg   <= pdc_pkg::TERM_D;
                            mcand_reg  <= {{(ACC_W-32){deriv_reg[31]}}, deriv_reg};
                            mplier_reg <= gain_d_reg;
                        end
                        default:
                        begin
                            term_reg <= pdc_pkg::TERM_D;
                        end
                    endcase
                end
                else
                begin
                    acc_reg    <= acc_reg + addend;
                    cnt_reg    <= cnt_reg + 5'd1;
                    mcand_reg  <= {mcand_reg[ACC_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[15:1]};
                end
            end
            pdc_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    drive_reg  <= drive_new;
                    clamp_reg  <= clamp_new;
                    remain_reg <= {target_reg[15], target_reg} - {last_reg[15], last_reg};
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, remain_reg, drive_reg};
    assign m_axis_tuser  = clamp_reg;

endmodule
